// ===== rtl/sgr_pkg.sv =====
// Shared constants and types for the stream group reverser.
package sgr_pkg;

    localparam int DEPTH       = 16;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int VALUE_WIDTH = 32;
    localparam int CFG_WIDTH   = 5;

    localparam logic [CFG_WIDTH-1:0] GROUP_SIZE_RESET = CFG_WIDTH'(2);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] element_value;
        logic                          list_end;
    } t_in;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] out_value;
        logic                          run_last;
        logic                          list_last;
    } t_out;

    // One command to every cell of the row in a cycle.
    typedef struct packed {
        logic push;       // shift toward the far end, new value enters cell 0
        logic pop_head;   // shift toward cell 0, cell 0 value leaves
        logic drop_tail;  // free the oldest occupied cell
    } t_cell_ctrl;

endpackage

// ===== rtl/stream_group_reverser.sv =====
// Top level of the stream group reverser: cell row, sequencer and output register.
//
// Usage:
//   Input requests (i_in_valid / o_in_ready) carry one signed list element and
//   an end-of-list flag. Elements stack up in a row of 16 cells. When the
//   stack holds group_size elements it is sent out newest first; when the end
//   flag arrives on a shorter group, that group is sent out oldest first.
//   Output requests (o_out_valid / i_out_ready) carry the value, run_last on
//   the final result of a group and list_last on the final result of a list.
//   group_size is written through i_cfg_we / i_cfg_data while idle; 0 acts as
//   1 and values above 16 act as 16. Reset sets it to 2 and empties the row.
// Flow:
//   An element that does not close a group is stacked and input stays open. An
//   element that closes a group of n starts the unloading of its n cells, one
//   cell shift or tail release per cycle while the output register is free or
//   draining; no input is taken during the unload. The first result is loaded
//   into the output register on the first unload step after the closing
//   element is accepted. A stalled receiver holds the output register and
//   freezes the row; a new element is still taken while the last result of a
//   group waits in the output register.
module stream_group_reverser (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sgr_pkg::t_in                      i_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sgr_pkg::t_out                     o_out,
    input  logic                              i_cfg_we,
    input  logic [sgr_pkg::CFG_WIDTH-1:0]     i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                                   r_state, n_state;
    logic                                   r_rev, n_rev;
    logic                                   r_list_end, n_list_end;
    logic [sgr_pkg::CFG_WIDTH-1:0]          r_group_size;
    logic                                   r_out_valid;
    sgr_pkg::t_out                          r_out;

    logic                                   w_in_fire;
    logic                                   w_step;
    logic                                   w_last;
    logic                                   w_full;
    logic [sgr_pkg::IDX_W-1:0]              w_k_idx;
    logic [sgr_pkg::DEPTH-1:0]              w_occ;
    logic [sgr_pkg::DEPTH-1:0]              w_occ_after;
    logic signed [sgr_pkg::VALUE_WIDTH-1:0] w_value      [sgr_pkg::DEPTH];
    logic signed [sgr_pkg::VALUE_WIDTH-1:0] w_tail_value [sgr_pkg::DEPTH];
    logic signed [sgr_pkg::VALUE_WIDTH-1:0] w_fwd_value;
    logic signed [sgr_pkg::VALUE_WIDTH-1:0] w_pop_value;
    sgr_pkg::t_cell_ctrl                    w_ctrl;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_fire   = i_in_valid & o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Advance the unload only when the output register is free or draining.
    assign w_step = (r_state == ST_EMIT) & (~r_out_valid | i_out_ready);

    // Hold the group size register; the user must write it only while idle, the block does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_group_size <= sgr_pkg::GROUP_SIZE_RESET;
        end else if (i_cfg_we) begin
            r_group_size <= i_cfg_data;
        end
    end

    // Clamp the group size into 1..DEPTH and turn it into a cell index.
    always_comb begin
        priority if (r_group_size == '0) begin
            w_k_idx = '0;
        end else if (r_group_size > sgr_pkg::CFG_WIDTH'(sgr_pkg::DEPTH)) begin
            w_k_idx = sgr_pkg::IDX_W'(sgr_pkg::DEPTH - 1);
        end else begin
            w_k_idx = sgr_pkg::IDX_W'(r_group_size - sgr_pkg::CFG_WIDTH'(1));
        end
    end

    // Occupancy after the push; the group is full once cell k-1 is taken.
    assign w_occ_after = {w_occ[sgr_pkg::DEPTH-2:0], 1'b1};
    assign w_full      = w_occ_after[w_k_idx];

    // Head and tail both leave the row empty when cell 1 is free.
    assign w_last = ~w_occ[1];

    always_comb begin
        w_ctrl.push      = w_in_fire;
        w_ctrl.pop_head  = w_step & r_rev;
        w_ctrl.drop_tail = w_step & ~r_rev;
    end

    // Cell row: cell 0 takes new elements and hands out the newest one.
    for (genvar gi = 0; gi < sgr_pkg::DEPTH; gi++) begin : g_cell
        logic signed [sgr_pkg::VALUE_WIDTH-1:0] w_prev_value, w_next_value;
        logic                                   w_prev_occ, w_next_occ;

        if (gi == 0) begin : g_head
            assign w_prev_value = i_in.element_value;
            assign w_prev_occ   = 1'b1;
        end else begin : g_body
            assign w_prev_value = w_value[gi-1];
            assign w_prev_occ   = w_occ[gi-1];
        end

        if (gi == sgr_pkg::DEPTH - 1) begin : g_end
            assign w_next_value = '0;
            assign w_next_occ   = 1'b0;
        end else begin : g_mid
            assign w_next_value = w_value[gi+1];
            assign w_next_occ   = w_occ[gi+1];
        end

        sgr_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_ctrl),
            .i_prev_value (w_prev_value),
            .i_prev_occ   (w_prev_occ),
            .i_next_value (w_next_value),
            .i_next_occ   (w_next_occ),
            .o_value      (w_value[gi]),
            .o_occ        (w_occ[gi]),
            .o_tail_value (w_tail_value[gi])
        );
    end

    // Only the tail cell drives a nonzero value, so an OR picks it.
    always_comb begin
        w_fwd_value = '0;
        for (int i = 0; i < sgr_pkg::DEPTH; i++) begin
            w_fwd_value = w_fwd_value | w_tail_value[i];
        end
    end

    assign w_pop_value = r_rev ? w_value[0] : w_fwd_value;

    // Sequencer: stack elements while idle, unload one per step.
    always_comb begin
        n_state    = r_state;
        n_rev      = r_rev;
        n_list_end = r_list_end;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_fire) begin
                    n_list_end = i_in.list_end;
                    if (w_full) begin
                        n_state = ST_EMIT;
                        n_rev   = 1'b1;
                    end else if (i_in.list_end) begin
                        n_state = ST_EMIT;
                        n_rev   = 1'b0;
                    end
                end
            end
            ST_EMIT: begin
                if (w_step && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_rev      <= 1'b0;
            r_list_end <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rev      <= n_rev;
            r_list_end <= n_list_end;
        end
    end

    // Output register: load on each step, drop valid once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out.out_value <= w_pop_value;
            r_out.run_last  <= w_last;
            r_out.list_last <= w_last & r_list_end;
        end
    end

    // The row never runs dry while unloading.
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> w_occ[0])
        else $error("unload with empty cell row");

    // Occupied cells form an unbroken run from cell 0.
    a_occ_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_occ & (w_occ + sgr_pkg::DEPTH'(1))) == '0))
        else $error("cell occupancy has a gap");

    // The final step of a group returns to idle with an empty row.
    a_last_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_last) |=> ((r_state == ST_IDLE) && (w_occ == '0)))
        else $error("group unload did not finish cleanly");

    // End of list only ever marks the end of a group.
    a_list_last_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.list_last) |-> r_out.run_last)
        else $error("list_last without run_last");

endmodule

// ===== rtl/sgr_cell.sv =====
// One storage cell of the reverser row: a value and an occupied flag.
module sgr_cell (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sgr_pkg::t_cell_ctrl                    i_ctrl,
    input  logic signed [sgr_pkg::VALUE_WIDTH-1:0] i_prev_value,
    input  logic                                   i_prev_occ,
    input  logic signed [sgr_pkg::VALUE_WIDTH-1:0] i_next_value,
    input  logic                                   i_next_occ,
    output logic signed [sgr_pkg::VALUE_WIDTH-1:0] o_value,
    output logic                                   o_occ,
    output logic signed [sgr_pkg::VALUE_WIDTH-1:0] o_tail_value
);

    logic signed [sgr_pkg::VALUE_WIDTH-1:0] r_value;
    logic                                   r_occ;
    logic                                   w_tail;

    // Oldest element sits in the last occupied cell.
    assign w_tail       = r_occ & ~i_next_occ;
    assign o_value      = r_value;
    assign o_occ        = r_occ;
    assign o_tail_value = w_tail ? r_value : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else if (i_ctrl.push) begin
            r_occ <= i_prev_occ;
        end else if (i_ctrl.pop_head) begin
            r_occ <= i_next_occ;
        end else if (i_ctrl.drop_tail && w_tail) begin
            r_occ <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_value <= i_prev_value;
        end else if (i_ctrl.pop_head) begin
            r_value <= i_next_value;
        end
    end

endmodule

// ===== tb/tb_stream_group_reverser.sv =====
// Self-checking testbench for stream_group_reverser: directed and random lists.
module tb_stream_group_reverser;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES = 24;    // settle margin, sized for a full group of 16
    localparam int STALL_LIMIT  = 3000;  // cycles with no request moving on either side

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    sgr_pkg::t_in                  in_data   = '0;
    logic                          out_ready = 1'b0;
    logic                          cfg_we    = 1'b0;
    logic [sgr_pkg::CFG_WIDTH-1:0] cfg_data  = '0;
    logic                          in_ready;
    logic                          out_valid;
    sgr_pkg::t_out                 out_data;

    // Predictor state: buffered elements, their count and the group size register.
    logic signed [sgr_pkg::VALUE_WIDTH-1:0] held_values [sgr_pkg::DEPTH];
    int                                     held_count;
    logic [sgr_pkg::CFG_WIDTH-1:0]          group_size_q;
    sgr_pkg::t_out                          reordered_values [$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int quiet_cycles   = 0;

    stream_group_reverser u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in        (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out       (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic int effective_group_size();
        if (group_size_q == '0)
            return 1;
        if (group_size_q > sgr_pkg::DEPTH)
            return sgr_pkg::DEPTH;
        return group_size_q;
    endfunction

    // Stack one element; emit the group reversed once full, or in order on a short end.
    task automatic reorder_element(input sgr_pkg::t_in item);
        sgr_pkg::t_out res;
        int            k;
        int            n;
        k = effective_group_size();
        if (held_count < sgr_pkg::DEPTH) begin
            held_values[held_count] = item.element_value;
            held_count++;
        end
        n = held_count;
        if (n >= k || item.list_end) begin
            for (int i = 0; i < n; i++) begin
                res.out_value = (n >= k) ? held_values[n - 1 - i] : held_values[i];
                res.run_last  = (i == n - 1);
                res.list_last = (i == n - 1) && item.list_end;
                reordered_values.push_back(res);
            end
            held_count = 0;
        end
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk) begin
        sgr_pkg::t_out want;
        if (rst_n && out_valid && out_ready) begin
            if (reordered_values.size() == 0) begin
                $display("%0t: unexpected result value %h run_last %b list_last %b",
                         $realtime, out_data.out_value, out_data.run_last, out_data.list_last);
                mismatch_count++;
            end else begin
                want = reordered_values.pop_front();
                if (out_data.out_value !== want.out_value) begin
                    $display("%0t: out_value expected %h actual %h",
                             $realtime, want.out_value, out_data.out_value);
                    mismatch_count++;
                end
                if (out_data.run_last !== want.run_last) begin
                    $display("%0t: run_last expected %b actual %b",
                             $realtime, want.run_last, out_data.run_last);
                    mismatch_count++;
                end
                if (out_data.list_last !== want.list_last) begin
                    $display("%0t: list_last expected %b actual %b",
                             $realtime, want.list_last, out_data.list_last);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no request moves for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles + 1 >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $realtime, STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Offer one request; valid stays up afterward until the next item or a drain lowers it.
    task automatic send_element(input logic signed [sgr_pkg::VALUE_WIDTH-1:0] value,
                                input logic last);
        sgr_pkg::t_in item;
        item.element_value = value;
        item.list_end      = last;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        reorder_element(item);
    endtask

    // Drop valid, hold until every expected result is out, then let the block settle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (reordered_values.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_group_size(input logic [sgr_pkg::CFG_WIDTH-1:0] size);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_data <= size;
        @(posedge clk);
        cfg_we   <= 1'b0;
        group_size_q = size;
    endtask

    function automatic logic signed [sgr_pkg::VALUE_WIDTH-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Reset group size of 2: extreme values, full pairs, and a lone element at list end.
    task automatic test_reset_group_size();
        send_element(32'sh7fff_ffff, 1'b0);
        send_element(32'sh8000_0000, 1'b0);
        send_element('1, 1'b0);
        send_element('0, 1'b1);
        send_element(32'sh5555_5555, 1'b1);
    endtask

    // Size 1 passes straight through; size 0 must act the same.
    task automatic test_pass_through();
        write_group_size(sgr_pkg::CFG_WIDTH'(1));
        send_element(32'sh0000_0001, 1'b0);
        send_element(32'shaaaa_aaaa, 1'b0);
        send_element(32'sh1234_5678, 1'b1);
        write_group_size('0);
        send_element(32'sh8000_0000, 1'b0);
        send_element(32'sh7fff_ffff, 1'b1);
    endtask

    // A short final group keeps its original order.
    task automatic test_short_final_group();
        write_group_size(sgr_pkg::CFG_WIDTH'(3));
        send_element(32'sh0000_00a1, 1'b0);
        send_element(32'sh0000_00b2, 1'b1);
    endtask

    // Lower the size under a partly filled group: the next element flushes all, reversed.
    task automatic test_shrink_while_filling();
        write_group_size(sgr_pkg::CFG_WIDTH'(5));
        send_element(32'sh0000_0011, 1'b0);
        send_element(32'sh0000_0022, 1'b0);
        send_element(32'sh0000_0033, 1'b0);
        write_group_size(sgr_pkg::CFG_WIDTH'(2));
        send_element(32'sh0000_0044, 1'b0);
        send_element(32'sh0000_0055, 1'b1);
    endtask

    // Sender holds off mid-list until all results are out, then resumes the list.
    task automatic test_pause_mid_list();
        write_group_size(sgr_pkg::CFG_WIDTH'(4));
        send_idle_pct = 18;
        stall_pct     = 18;
        send_element(random_value(), 1'b0);
        send_element(random_value(), 1'b0);
        wait_drained();
        send_element(random_value(), 1'b0);
        send_element(random_value(), 1'b0);
        send_element(random_value(), 1'b1);
    endtask

    // Lists of random length and content; one in ten runs on into the next list.
    task automatic run_random_lists(input int items);
        int   sent;
        int   len;
        logic closed;
        sent = 0;
        while (sent < items) begin
            len    = $urandom_range(1, 2 * effective_group_size() + 2);
            closed = ($urandom_range(0, 9) != 0);
            for (int i = 0; i < len; i++)
                send_element(random_value(), closed && (i == len - 1));
            sent += len;
        end
    endtask

    // Walk through group sizes, extremes included, rotating the idle phases.
    task automatic test_random_phases();
        int sizes [12] = '{2, 1, 3, 16, 4, 0, 31, 7, 17, 5, 8, 2};
        int send_pct [4] = '{0, 51, 0, 18};
        int hold_pct [4] = '{0, 0, 51, 18};
        foreach (sizes[p]) begin
            write_group_size(sgr_pkg::CFG_WIDTH'(sizes[p]));
            send_idle_pct = send_pct[p % 4];
            stall_pct     = hold_pct[p % 4];
            run_random_lists(25);
        end
    endtask

    initial begin
        held_count   = 0;
        group_size_q = sgr_pkg::GROUP_SIZE_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_group_size();
        test_pass_through();
        test_short_final_group();
        test_shrink_while_filling();
        test_pause_mid_list();
        test_random_phases();

        wait_drained();
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
